FILE: rtl/mwspi_pkg.sv
// ----------------------------------------------------------------------------
// mwspi_pkg
// shared widths, constants and types of the mecanum wheel speed pi block
// ----------------------------------------------------------------------------
package mwspi_pkg;

  localparam int NUM_WHEELS = 4;
  localparam int WHEEL_W    = $clog2(NUM_WHEELS);
  localparam int NUM_REGS   = 2 * NUM_WHEELS;
  localparam int CFG_IDX_W  = $clog2(NUM_REGS) + 1;

  localparam int IN_W       = 16;
  localparam int GAIN_W     = 16;
  localparam int GAIN_FRAC  = 10;
  localparam int ERR_W      = 20;
  localparam int DUTY_W     = 14;
  localparam int DUTY_MAX   = 2 ** DUTY_W - 1;

  localparam int OUTPUT_LIMIT = 10000;
  localparam int ACC_LIMIT    = OUTPUT_LIMIT * 256;
  localparam int ACC_W        = $clog2(ACC_LIMIT + 1) + 1;

  // encoder count to q8.8 speed, 0.828125 per count
  localparam logic signed [8:0] SPEED_PER_COUNT = 9'sd212;

  localparam logic signed [GAIN_W-1:0] KP_RESET [NUM_WHEELS] =
    '{-16'sd16691, -16'sd14336, -16'sd15360, -16'sd16691};
  localparam logic signed [GAIN_W-1:0] KI_RESET [NUM_WHEELS] =
    '{-16'sd3379, -16'sd2560, -16'sd3072, -16'sd2867};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP_WHEEL0 = 4'd0,
    REG_KI_WHEEL0 = 4'd1,
    REG_KP_WHEEL1 = 4'd2,
    REG_KI_WHEEL1 = 4'd3,
    REG_KP_WHEEL2 = 4'd4,
    REG_KI_WHEEL2 = 4'd5,
    REG_KP_WHEEL3 = 4'd6,
    REG_KI_WHEEL3 = 4'd7
  } reg_idx_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic               load_in;
    logic               do_err;
    logic               do_mul;
    logic               do_acc;
    logic               load_out;
    logic [WHEEL_W-1:0] wheel;
  } dp_cmd_t;

endpackage

FILE: rtl/mwspi_ctrl.sv
// ----------------------------------------------------------------------------
// mwspi_ctrl
// sequencer: walks the four wheels through error, multiply and accumulate
// ----------------------------------------------------------------------------
module mwspi_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output mwspi_pkg::dp_cmd_t  cmd
);
  import mwspi_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ERR  = 5'b00010,
    S_MUL  = 5'b00100,
    S_ACC  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  localparam logic [WHEEL_W-1:0] WHEEL_LAST = WHEEL_W'(NUM_WHEELS - 1);

  state_t             state_r, state_nxt;
  logic [WHEEL_W-1:0] wheel_r, wheel_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    wheel_nxt    = wheel_r;
    cmd          = '0;
    cmd.wheel    = wheel_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          wheel_nxt   = '0;
          state_nxt   = S_ERR;
        end
      end
      S_ERR: begin
        cmd.do_err = 1'b1;
        state_nxt  = S_MUL;
      end
      S_MUL: begin
        cmd.do_mul = 1'b1;
        state_nxt  = S_ACC;
      end
      S_ACC: begin
        cmd.do_acc = 1'b1;
        if (wheel_r == WHEEL_LAST) begin
          state_nxt = S_DONE;
        end else begin
          wheel_nxt = wheel_r + 1'b1;
          state_nxt = S_ERR;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = cmd.load_out ? 1'b1 : (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wheel_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wheel_r     <= wheel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // an accepted item always starts on the first wheel
  a_start_wheel0: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_ERR && wheel_r == '0)
    else $error("item did not start at wheel 0");

  // all four wheels are done before the result is offered
  a_last_wheel_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ACC && wheel_r == WHEEL_LAST |=> state_r == S_DONE)
    else $error("sequencer left the last wheel without finishing");

  // a finished item waits while the previous result is still held
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE && out_valid_r && !out_ready |=> state_r == S_DONE && out_valid_r)
    else $error("waiting result overwritten");

endmodule

FILE: rtl/mwspi_dp.sv
// ----------------------------------------------------------------------------
// mwspi_dp
// datapath: gains, per-wheel state, one wheel of pi arithmetic per three steps
// ----------------------------------------------------------------------------
module mwspi_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mwspi_pkg::dp_cmd_t                  cmd,
  input  logic                                cfg_we,
  input  logic [mwspi_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mwspi_pkg::GAIN_W-1:0]        cfg_wdata,
  input  logic signed [mwspi_pkg::IN_W-1:0]   vel_x,
  input  logic signed [mwspi_pkg::IN_W-1:0]   vel_y,
  input  logic signed [mwspi_pkg::IN_W-1:0]   vel_rot,
  input  logic signed [mwspi_pkg::IN_W-1:0]   count [mwspi_pkg::NUM_WHEELS],
  output logic [mwspi_pkg::DUTY_W-1:0]        duty [mwspi_pkg::NUM_WHEELS],
  output logic                                dir [mwspi_pkg::NUM_WHEELS]
);
  import mwspi_pkg::*;

  localparam int TGT_W  = IN_W + 2;
  localparam int MEAS_W = IN_W + 9;
  localparam int DIFF_W = MEAS_W + 1;
  localparam int PP_W   = GAIN_W + ERR_W + 1;
  localparam int PI_W   = GAIN_W + ERR_W;
  localparam int SUM_W  = PP_W + 1;
  localparam int INC_W  = SUM_W - GAIN_FRAC;
  localparam int AS_W   = INC_W + 1;
  localparam int MAG_W  = ACC_W - 1 - 8;
  localparam int ERR_HI = 2 ** (ERR_W - 1) - 1;
  localparam int ERR_LO = -(2 ** (ERR_W - 1));

  // configuration and state
  logic signed [GAIN_W-1:0] kp_r [NUM_WHEELS], kp_nxt [NUM_WHEELS];
  logic signed [GAIN_W-1:0] ki_r [NUM_WHEELS], ki_nxt [NUM_WHEELS];
  logic signed [ERR_W-1:0]  prev_r [NUM_WHEELS];
  logic signed [ACC_W-1:0]  acc_r [NUM_WHEELS];

  // captured item
  logic signed [IN_W-1:0]   vx_r, vy_r, vz_r;
  logic signed [IN_W-1:0]   cnt_r [NUM_WHEELS];

  // stage registers
  logic signed [ERR_W-1:0]  e_r;
  logic signed [PP_W-1:0]   prod_p_r;
  logic signed [PI_W-1:0]   prod_i_r;

  // results
  logic [DUTY_W-1:0]        res_duty_r [NUM_WHEELS];
  logic                     res_dir_r [NUM_WHEELS];
  logic [DUTY_W-1:0]        out_duty_r [NUM_WHEELS];
  logic                     out_dir_r [NUM_WHEELS];

  // error step
  logic                     sign_x, sign_z;
  logic signed [TGT_W-1:0]  tgt;
  logic signed [MEAS_W-1:0] meas;
  logic signed [DIFF_W-1:0] diff;
  logic signed [ERR_W-1:0]  e_new;

  // multiply step
  logic signed [ERR_W:0]    de;
  logic signed [PP_W-1:0]   prod_p;
  logic signed [PI_W-1:0]   prod_i;

  // accumulate step
  logic signed [SUM_W-1:0]  sum;
  logic signed [INC_W-1:0]  inc;
  logic signed [AS_W-1:0]   acc_sum;
  logic signed [ACC_W-1:0]  acc_new;
  logic [ACC_W-1:0]         acc_abs;
  logic [MAG_W-1:0]         mag;
  logic [DUTY_W-1:0]        duty_new;
  logic                     positive;
  logic                     left_side;
  logic                     dir_new;

  // register writes
  always_comb begin
    kp_nxt = kp_r;
    ki_nxt = ki_r;
    if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_KP_WHEEL0: kp_nxt[0] = cfg_wdata;
        REG_KI_WHEEL0: ki_nxt[0] = cfg_wdata;
        REG_KP_WHEEL1: kp_nxt[1] = cfg_wdata;
        REG_KI_WHEEL1: ki_nxt[1] = cfg_wdata;
        REG_KP_WHEEL2: kp_nxt[2] = cfg_wdata;
        REG_KI_WHEEL2: ki_nxt[2] = cfg_wdata;
        REG_KP_WHEEL3: kp_nxt[3] = cfg_wdata;
        REG_KI_WHEEL3: ki_nxt[3] = cfg_wdata;
        default: ;
      endcase
    end
  end

  // target and measured speed, saturated error
  always_comb begin
    sign_x = (cmd.wheel == WHEEL_W'(0)) || (cmd.wheel == WHEEL_W'(3));
    sign_z = cmd.wheel[WHEEL_W-1];
    tgt    = (sign_x ? TGT_W'(vx_r) : -TGT_W'(vx_r)) + TGT_W'(vy_r)
           + (sign_z ? TGT_W'(vz_r) : -TGT_W'(vz_r));
    meas   = cnt_r[cmd.wheel] * SPEED_PER_COUNT;
    diff   = DIFF_W'(tgt) - DIFF_W'(meas);
    if (diff > DIFF_W'(ERR_HI)) begin
      e_new = ERR_W'(ERR_HI);
    end else if (diff < DIFF_W'(ERR_LO)) begin
      e_new = ERR_W'(ERR_LO);
    end else begin
      e_new = diff[ERR_W-1:0];
    end
  end

  // gain products
  always_comb begin
    de     = (ERR_W + 1)'(e_r) - (ERR_W + 1)'(prev_r[cmd.wheel]);
    prod_p = kp_r[cmd.wheel] * de;
    prod_i = ki_r[cmd.wheel] * e_r;
  end

  // floor shift, accumulate, clamp, duty and direction
  always_comb begin
    sum     = SUM_W'(prod_p_r) + SUM_W'(prod_i_r);
    inc     = sum[SUM_W-1:GAIN_FRAC];
    acc_sum = AS_W'(inc) + AS_W'(acc_r[cmd.wheel]);
    if (acc_sum > AS_W'(ACC_LIMIT)) begin
      acc_new = ACC_W'(ACC_LIMIT);
    end else if (acc_sum < -AS_W'(ACC_LIMIT)) begin
      acc_new = -ACC_W'(ACC_LIMIT);
    end else begin
      acc_new = acc_sum[ACC_W-1:0];
    end
    acc_abs   = acc_new[ACC_W-1] ? ACC_W'(-acc_new) : ACC_W'(acc_new);
    mag       = acc_abs[ACC_W-2:8];
    duty_new  = (mag > MAG_W'(DUTY_MAX)) ? DUTY_W'(DUTY_MAX) : mag[DUTY_W-1:0];
    positive  = !acc_new[ACC_W-1] && (duty_new != '0);
    left_side = !cmd.wheel[WHEEL_W-1];
    dir_new   = left_side ? !positive : positive;
  end

  // control-relevant state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r <= KP_RESET;
      ki_r <= KI_RESET;
      for (int i = 0; i < NUM_WHEELS; i++) begin
        prev_r[i] <= '0;
        acc_r[i]  <= '0;
      end
    end else begin
      kp_r <= kp_nxt;
      ki_r <= ki_nxt;
      if (cmd.do_mul) begin
        prev_r[cmd.wheel] <= e_r;
      end
      if (cmd.do_acc) begin
        acc_r[cmd.wheel] <= acc_new;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      vx_r  <= vel_x;
      vy_r  <= vel_y;
      vz_r  <= vel_rot;
      cnt_r <= count;
    end
    if (cmd.do_err) begin
      e_r <= e_new;
    end
    if (cmd.do_mul) begin
      prod_p_r <= prod_p;
      prod_i_r <= prod_i;
    end
    if (cmd.do_acc) begin
      res_duty_r[cmd.wheel] <= duty_new;
      res_dir_r[cmd.wheel]  <= dir_new;
    end
    if (cmd.load_out) begin
      out_duty_r <= res_duty_r;
      out_dir_r  <= res_dir_r;
    end
  end

  assign duty = out_duty_r;
  assign dir  = out_dir_r;

  // clamp and magnitude keep the duty within the output limit
  a_duty_limit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_acc |=> res_duty_r[$past(cmd.wheel)] <= DUTY_W'(OUTPUT_LIMIT))
    else $error("duty above output limit");

  // zero duty takes the else polarity
  a_zero_polarity: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_acc |=> res_duty_r[$past(cmd.wheel)] != '0
                || res_dir_r[$past(cmd.wheel)] == !$past(cmd.wheel[WHEEL_W-1]))
    else $error("zero duty with drive polarity");

endmodule

FILE: rtl/mecanum_wheel_speed_pi_top.sv
// ----------------------------------------------------------------------------
// mecanum_wheel_speed_pi_top
// four-wheel mecanum speed loop: kinematics, encoder speed and incremental pi
// ----------------------------------------------------------------------------
//
//   channel   handshake               payload
//   in        in_valid / in_ready     vel_x, vel_y, vel_rot, count_wheel0..3
//   out       out_valid / out_ready   duty_wheel0..3, dir_wheel0..3
//   cfg       cfg_we (no wait)        cfg_index, cfg_wdata (kp/ki per wheel)
//
// each item is stepped by one shared error / multiply / accumulate unit over
// the four wheels, wheel by wheel through its error, multiply and accumulate
// steps, and the result is then handed to the output register. a new item is
// accepted only after the previous one has been handed over.
// a held result does not block acceptance; a finished item waits in its
// staging registers until the output register is free.
// synchronous active-low reset clears gains to their defaults and the error
// and accumulator state to zero.
// ----------------------------------------------------------------------------
module mecanum_wheel_speed_pi_top (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [mwspi_pkg::IN_W-1:0]   in_vel_x,
  input  logic signed [mwspi_pkg::IN_W-1:0]   in_vel_y,
  input  logic signed [mwspi_pkg::IN_W-1:0]   in_vel_rot,
  input  logic signed [mwspi_pkg::IN_W-1:0]   in_count_wheel0,
  input  logic signed [mwspi_pkg::IN_W-1:0]   in_count_wheel1,
  input  logic signed [mwspi_pkg::IN_W-1:0]   in_count_wheel2,
  input  logic signed [mwspi_pkg::IN_W-1:0]   in_count_wheel3,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [mwspi_pkg::DUTY_W-1:0]        out_duty_wheel0,
  output logic [mwspi_pkg::DUTY_W-1:0]        out_duty_wheel1,
  output logic [mwspi_pkg::DUTY_W-1:0]        out_duty_wheel2,
  output logic [mwspi_pkg::DUTY_W-1:0]        out_duty_wheel3,
  output logic                                out_dir_wheel0,
  output logic                                out_dir_wheel1,
  output logic                                out_dir_wheel2,
  output logic                                out_dir_wheel3,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [mwspi_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mwspi_pkg::GAIN_W-1:0]        cfg_wdata
);
  import mwspi_pkg::*;

  dp_cmd_t                cmd;
  logic signed [IN_W-1:0] count [NUM_WHEELS];
  logic [DUTY_W-1:0]      duty [NUM_WHEELS];
  logic                   dir [NUM_WHEELS];

  // encoder counts gathered per wheel
  assign count[0] = in_count_wheel0;
  assign count[1] = in_count_wheel1;
  assign count[2] = in_count_wheel2;
  assign count[3] = in_count_wheel3;

  // sequencer: handshakes and per-wheel step commands
  mwspi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // arithmetic, gains, loop state and output register
  mwspi_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .vel_x     (in_vel_x),
    .vel_y     (in_vel_y),
    .vel_rot   (in_vel_rot),
    .count     (count),
    .duty      (duty),
    .dir       (dir)
  );

  // result fields
  assign out_duty_wheel0 = duty[0];
  assign out_duty_wheel1 = duty[1];
  assign out_duty_wheel2 = duty[2];
  assign out_duty_wheel3 = duty[3];
  assign out_dir_wheel0  = dir[0];
  assign out_dir_wheel1  = dir[1];
  assign out_dir_wheel2  = dir[2];
  assign out_dir_wheel3  = dir[3];

endmodule
